[hdl/rational_arithmetic_unit_top_assert.svh]
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define RAU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rau assertion failed");

// Implication checked outside reset.
`define RAU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau assertion failed");

`endif

[hdl/rau_pkg.sv]
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W         = OPERAND_WIDTH + 1;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 32;
  localparam int IN_DATA_W     = 72;
  localparam int OUT_DATA_W    = 72;
  localparam int CNT_W         = $clog2(MAG_W + 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_DIV    = 3'd3;
  localparam logic [2:0] OP_REDUCE = 3'd4;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL0,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_DIV_GCD,
    CMD_DIV_NUM,
    CMD_DIV_DEN,
    CMD_DIV_STEP,
    CMD_GCD_NEXT,
    CMD_SET_NUM,
    CMD_SET_DEN,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic quick;
    logic reduce;
    logic addsub;
    logic y_zero;
    logic div_last;
    logic out_free;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_GCD,
    ST_GDIV,
    ST_GNEXT,
    ST_NDIV,
    ST_NSET,
    ST_DDIV,
    ST_DSET,
    ST_FINISH
  } state_t;

endpackage

[hdl/rau_datapath.sv]
module rau_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rau_pkg::cmd_t                     cmd,
  output rau_pkg::status_t                  status,
  input  logic [rau_pkg::IN_DATA_W-1:0]     in_data,
  output logic [rau_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int W = rau_pkg::OPERAND_WIDTH;
  localparam int M = rau_pkg::MAG_W;

  logic [2:0]          in_op;
  logic signed [W-1:0] in_a, in_b, in_c, in_d;
  logic                in_err, in_zero_red;

  logic [2:0]          op;
  logic signed [W-1:0] a, b, c, d;
  logic                sign;
  logic                quick;
  logic [M-1:0]        ma, mb, x, y, dvs, rem, quo;
  logic [rau_pkg::CNT_W-1:0] cnt;
  logic signed [rau_pkg::PROD_W-1:0] prod;
  logic signed [rau_pkg::NUM_W-1:0]  num;
  logic signed [rau_pkg::DEN_W-1:0]  den;
  logic                err;

  logic signed [W-1:0] mul_l, mul_r;
  logic signed [rau_pkg::PROD_W-1:0] mul_p;
  logic [M-1:0]        shifted;
  logic [M:0]          trial;
  logic [rau_pkg::NUM_W-1:0] quo_ext;

  assign in_op = in_data[2:0];
  assign in_a  = in_data[3 +: W];
  assign in_b  = in_data[19 +: W];
  assign in_c  = in_data[35 +: W];
  assign in_d  = in_data[51 +: W];

  assign in_err = (in_op > rau_pkg::OP_REDUCE) || (in_b == '0) ||
                  ((in_op != rau_pkg::OP_REDUCE) && (in_d == '0)) ||
                  ((in_op == rau_pkg::OP_DIV) && (in_c == '0));
  assign in_zero_red = (in_op == rau_pkg::OP_REDUCE) && (in_a == '0);

  function automatic logic [rau_pkg::MAG_W-1:0] mag(input logic signed [W-1:0] v);
    logic [rau_pkg::MAG_W-1:0] e;
    e = {v[W-1], v};
    return v[W-1] ? (~e + 1'b1) : e;
  endfunction

  // shared multiplier operand select
  always_comb begin
    mul_l = a;
    mul_r = d;
    unique case (cmd)
      rau_pkg::CMD_MUL0: begin
        mul_l = a;
        mul_r = (op == rau_pkg::OP_MUL) ? c : d;
      end
      rau_pkg::CMD_MUL1: begin
        mul_l = b;
        mul_r = (op == rau_pkg::OP_MUL) ? d : c;
      end
      default: begin
        mul_l = b;
        mul_r = d;
      end
    endcase
  end
  assign mul_p = mul_l * mul_r;

  assign shifted = {rem[M-2:0], quo[M-1]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs};
  assign quo_ext = {{(rau_pkg::NUM_W-M){1'b0}}, quo};

  always_ff @(posedge clk) begin
    unique case (cmd)
      rau_pkg::CMD_LOAD: begin
        op    <= in_op;
        a     <= in_a;
        b     <= in_b;
        c     <= in_c;
        d     <= in_d;
        ma    <= mag(in_a);
        mb    <= mag(in_b);
        x     <= mag(in_a);
        y     <= mag(in_b);
        sign  <= in_a[W-1] ^ in_b[W-1];
        num   <= '0;
        den   <= rau_pkg::DEN_W'(1);
        err   <= in_err;
        quick <= in_err || in_zero_red;
      end
      rau_pkg::CMD_MUL0: prod <= mul_p;
      rau_pkg::CMD_MUL1: begin
        num  <= rau_pkg::NUM_W'(prod);
        prod <= mul_p;
      end
      rau_pkg::CMD_MUL2: begin
        if (op == rau_pkg::OP_ADD) begin
          num <= num + rau_pkg::NUM_W'(prod);
        end else if (op == rau_pkg::OP_SUB) begin
          num <= num - rau_pkg::NUM_W'(prod);
        end else begin
          den <= rau_pkg::DEN_W'(prod);
        end
        prod <= mul_p;
      end
      rau_pkg::CMD_MUL3: den <= rau_pkg::DEN_W'(prod);
      rau_pkg::CMD_DIV_GCD: begin
        quo <= x;
        dvs <= y;
        rem <= '0;
        cnt <= rau_pkg::CNT_W'(M);
      end
      rau_pkg::CMD_DIV_NUM: begin
        quo <= ma;
        dvs <= x;
        rem <= '0;
        cnt <= rau_pkg::CNT_W'(M);
      end
      rau_pkg::CMD_DIV_DEN: begin
        quo <= mb;
        dvs <= x;
        rem <= '0;
        cnt <= rau_pkg::CNT_W'(M);
      end
      rau_pkg::CMD_DIV_STEP: begin
        // restoring division, one quotient bit per beat of the loop
        if (!trial[M]) begin
          rem <= trial[M-1:0];
          quo <= {quo[M-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[M-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      rau_pkg::CMD_GCD_NEXT: begin
        x <= y;
        y <= rem;
      end
      rau_pkg::CMD_SET_NUM: num <= sign ? (~quo_ext + 1'b1) : quo_ext;
      rau_pkg::CMD_SET_DEN: den <= rau_pkg::DEN_W'(quo);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == rau_pkg::CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == rau_pkg::CMD_EMIT) begin
      out_data <= {6'b0, err, den, num};
    end
  end

  always_comb begin
    status.quick    = quick;
    status.reduce   = (op == rau_pkg::OP_REDUCE);
    status.addsub   = (op == rau_pkg::OP_ADD) || (op == rau_pkg::OP_SUB);
    status.y_zero   = (y == '0);
    status.div_last = (cnt == rau_pkg::CNT_W'(1));
    status.out_free = !out_valid || out_ready;
  end

endmodule

[hdl/rau_controller.sv]
module rau_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rau_pkg::status_t status,
  output rau_pkg::cmd_t    cmd
);

  rau_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = rau_pkg::CMD_NONE;
    in_ready   = 1'b0;
    unique case (state)
      rau_pkg::ST_IDLE: begin
        // no beat is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd        = rau_pkg::CMD_LOAD;
          state_next = rau_pkg::ST_DISPATCH;
        end
      end
      rau_pkg::ST_DISPATCH: begin
        if (status.quick) begin
          state_next = rau_pkg::ST_FINISH;
        end else if (status.reduce) begin
          state_next = rau_pkg::ST_GCD;
        end else begin
          state_next = rau_pkg::ST_MUL0;
        end
      end
      rau_pkg::ST_MUL0: begin
        cmd        = rau_pkg::CMD_MUL0;
        state_next = rau_pkg::ST_MUL1;
      end
      rau_pkg::ST_MUL1: begin
        cmd        = rau_pkg::CMD_MUL1;
        state_next = rau_pkg::ST_MUL2;
      end
      rau_pkg::ST_MUL2: begin
        cmd        = rau_pkg::CMD_MUL2;
        state_next = status.addsub ? rau_pkg::ST_MUL3 : rau_pkg::ST_FINISH;
      end
      rau_pkg::ST_MUL3: begin
        cmd        = rau_pkg::CMD_MUL3;
        state_next = rau_pkg::ST_FINISH;
      end
      rau_pkg::ST_GCD: begin
        if (status.y_zero) begin
          cmd        = rau_pkg::CMD_DIV_NUM;
          state_next = rau_pkg::ST_NDIV;
        end else begin
          cmd        = rau_pkg::CMD_DIV_GCD;
          state_next = rau_pkg::ST_GDIV;
        end
      end
      rau_pkg::ST_GDIV: begin
        cmd = rau_pkg::CMD_DIV_STEP;
        if (status.div_last) state_next = rau_pkg::ST_GNEXT;
      end
      rau_pkg::ST_GNEXT: begin
        cmd        = rau_pkg::CMD_GCD_NEXT;
        state_next = rau_pkg::ST_GCD;
      end
      rau_pkg::ST_NDIV: begin
        cmd = rau_pkg::CMD_DIV_STEP;
        if (status.div_last) state_next = rau_pkg::ST_NSET;
      end
      rau_pkg::ST_NSET: begin
        cmd        = rau_pkg::CMD_SET_NUM;
        state_next = rau_pkg::ST_DSET;
      end
      rau_pkg::ST_DSET: begin
        // gcd is still in x, start the denominator divide
        cmd        = rau_pkg::CMD_DIV_DEN;
        state_next = rau_pkg::ST_DDIV;
      end
      rau_pkg::ST_DDIV: begin
        cmd = rau_pkg::CMD_DIV_STEP;
        if (status.div_last) state_next = rau_pkg::ST_FINISH;
      end
      rau_pkg::ST_FINISH: begin
        if (status.out_free) begin
          if (status.reduce && !status.quick) begin
            cmd = rau_pkg::CMD_SET_DEN;
            state_next = rau_pkg::ST_MUL3;
          end else begin
            cmd = rau_pkg::CMD_EMIT;
            state_next = rau_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = rau_pkg::ST_IDLE;
    endcase
    // after the denominator is set, ST_MUL3 is not wanted for reduce
    if (state == rau_pkg::ST_MUL3 && status.reduce) begin
      cmd        = rau_pkg::CMD_EMIT;
      state_next = status.out_free ? rau_pkg::ST_IDLE : rau_pkg::ST_MUL3;
      if (!status.out_free) cmd = rau_pkg::CMD_NONE;
    end
  end

endmodule

[hdl/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit: add, subtract, multiply, divide, reduce.
// Add/sub step through multiplier states MUL0..MUL3, mul/div MUL0..MUL2, and an error or
// zero-numerator reduce skips them; shared 16x16 multiplier used once per product.
// Reduce: a serial divide per Euclid remainder step, then numerator/denominator divides.
// One item in flight; next beat accepted the cycle after the result is registered.
// Reset: synchronous active-high rst clears the controller and output valid.
module rational_arithmetic_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[2:0], first_numerator, first_denominator, second_numerator,
  // second_denominator (16 each), zero pad
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_numerator[32:0], result_denominator[64:33], error_flag[65], zero pad
  output logic [71:0] m_tdata
);

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t status;

  rau_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rau_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule

[hdl/rau_checker.sv]
`include "rational_arithmetic_unit_top_assert.svh"

module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  `RAU_ASSERT_ALWAYS(a_den_nonzero, !m_tvalid || (m_tdata[64:33] != 32'd0))
  `RAU_ASSERT_IMPL(a_err_answer, m_tvalid && m_tdata[65], (m_tdata[32:0] == 33'd0) && (m_tdata[64:33] == 32'd1))
  `RAU_ASSERT_IMPL(a_busy_after_beat, s_tvalid && s_tready, ##1 !s_tready)
  `RAU_ASSERT_IMPL(a_out_holds, m_tvalid && !m_tready, ##1 m_tvalid)

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
